FILE: rtl/fbra_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// fbra_pkg
// Shared constants, operation codes and control types of the frame budget
// round-robin allocator.
// ============================================================================
package fbra_pkg;

    // Default sizes of the cell table.
    localparam int DEF_PRODUCERS  = 4;
    localparam int DEF_STAGES     = 5;
    localparam int DEF_COUNT_BITS = 16;

    // Urgent, normal and preload.
    localparam int PRIORITIES     = 3;

    // One limit register per possible stage.
    localparam int NUM_LIMIT_REGS = 5;

    // Operation codes of the kind field.
    localparam logic [2:0] KIND_BEGIN   = 3'd0;
    localparam logic [2:0] KIND_DECLARE = 3'd1;
    localparam logic [2:0] KIND_SEAL    = 3'd2;
    localparam logic [2:0] KIND_ACQUIRE = 3'd3;
    localparam logic [2:0] KIND_DEFER   = 3'd4;
    localparam logic [2:0] KIND_QUERY   = 3'd5;

    // Commands from the sequencer to the round-robin unit.
    typedef struct packed {
        logic cur_load;    // load cursor, clear local grants
        logic avail_load;  // load the stage budget
        logic ld;          // capture one demand
        logic reserve;     // apply the terrain urgent floor
        logic step;        // hand out one unit
    } rr_cmd_t;

    // Status from the round-robin unit.
    typedef struct packed {
        logic done;        // budget spent or no demand left
    } rr_stat_t;

endpackage

FILE: rtl/fbra_ram.sv
`timescale 1ns / 1ps
// ============================================================================
// fbra_ram
// Generic single-write, single-read memory with registered read data.
// ============================================================================
module fbra_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata <= mem_reg[raddr];
    end

endmodule

FILE: rtl/fbra_rr.sv
`timescale 1ns / 1ps
// ============================================================================
// fbra_rr
// Round-robin grant unit: holds the demands and grants of one stage and
// priority, applies the terrain floor and hands out one unit per step cycle.
// ============================================================================
module fbra_rr #(
    parameter int PRODUCERS  = fbra_pkg::DEF_PRODUCERS,
    parameter int COUNT_BITS = fbra_pkg::DEF_COUNT_BITS,
    localparam int PB = $clog2(PRODUCERS)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  fbra_pkg::rr_cmd_t     cmd,
    input  logic [PB-1:0]         idx,
    input  logic [COUNT_BITS-1:0] ld_data,
    input  logic [15:0]           budget,
    input  logic [15:0]           reserve,
    input  logic [PB-1:0]         cur_in,
    output logic [PB-1:0]         cur_out,
    output logic [COUNT_BITS-1:0] gr_out,
    output fbra_pkg::rr_stat_t    stat
);

    localparam int W = (COUNT_BITS > 16) ? COUNT_BITS : 16;

    logic [COUNT_BITS-1:0] dem_reg [PRODUCERS];
    logic [COUNT_BITS-1:0] gr_reg  [PRODUCERS];
    logic [15:0]           avail_reg;
    logic [PB-1:0]         cur_reg;

    logic [PB-1:0]         cand [PRODUCERS];
    logic [PRODUCERS-1:0]  hit;
    logic                  found;
    logic [PB-1:0]         sel;
    logic [PB-1:0]         sel_next;
    logic [W-1:0]          r_w;
    logic                  done;

    // Search from the cursor for the first producer still short of demand.
    always_comb
    begin
        int pi;
        found = 1'b0;
        sel   = '0;
        for (int off = 0; off < PRODUCERS; off++)
        begin
            pi = int'(cur_reg) + off;
            if (pi >= PRODUCERS)
            begin
                pi = pi - PRODUCERS;
            end
            cand[off] = PB'(pi);
            hit[off]  = gr_reg[cand[off]] < dem_reg[cand[off]];
        end
        for (int off = PRODUCERS - 1; off >= 0; off--)
        begin
            if (hit[off])
            begin
                found = 1'b1;
                sel   = cand[off];
            end
        end
        sel_next = (int'(sel) == PRODUCERS - 1) ? '0 : PB'(int'(sel) + 1);
    end

    // Terrain floor: the smallest of demand, budget left and reserve.
    always_comb
    begin
        r_w = W'(dem_reg[0]);
        if (W'(avail_reg) < r_w)
        begin
            r_w = W'(avail_reg);
        end
        if (W'(reserve) < r_w)
        begin
            r_w = W'(reserve);
        end
    end

    assign done      = (avail_reg == '0) || !found;
    assign stat.done = done;
    assign cur_out   = cur_reg;
    assign gr_out    = gr_reg[idx];

    // Budget and cursor.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            avail_reg <= '0;
            cur_reg   <= '0;
        end
        else
        begin
            if (cmd.avail_load)
            begin
                avail_reg <= budget;
            end
            if (cmd.cur_load)
            begin
                cur_reg <= cur_in;
            end
            if (cmd.reserve)
            begin
                avail_reg <= avail_reg - 16'(r_w);
                if (r_w != '0 && cur_reg == '0)
                begin
                    cur_reg <= PB'(1);
                end
            end
            if (cmd.step && !done)
            begin
                avail_reg <= avail_reg - 16'd1;
                cur_reg   <= sel_next;
            end
        end
    end

    // Local demand and grant counters.
    always_ff @(posedge clk)
    begin
        if (cmd.cur_load)
        begin
            for (int i = 0; i < PRODUCERS; i++)
            begin
                gr_reg[i] <= '0;
            end
        end
        if (cmd.ld)
        begin
            dem_reg[idx] <= ld_data;
        end
        if (cmd.reserve)
        begin
            gr_reg[0] <= COUNT_BITS'(r_w);
        end
        if (cmd.step && !done)
        begin
            gr_reg[sel] <= gr_reg[sel] + 1'b1;
        end
    end

endmodule

FILE: rtl/frame_budget_round_robin_allocator.sv
`timescale 1ns / 1ps
// ============================================================================
// frame_budget_round_robin_allocator
// Per-frame unit budget arbiter over producer, stage and priority cells.
// ============================================================================
// Usage:
// Commands enter on the input channel (in_valid, in_stall) and each gives
// exactly one result word on the output channel (out_valid, out_stall).
// The user must write stage limits on the cfg port only while the block is
// idle; the block itself does not enforce this.
// The block works on one command at a time; in_stall stays high meanwhile.
// Commands share the single read and write port of the cell tables, and a
// seal runs the round-robin unit, which grants one unit per cycle.
// After reset a clearing pass zeroes all tables, during which no command
// is accepted. A finished result word waits in the output register while
// the receiver stalls; the next command may be accepted, and its result
// waits until the output register is free.
// ============================================================================
module frame_budget_round_robin_allocator #(
    parameter int PRODUCERS  = fbra_pkg::DEF_PRODUCERS,
    parameter int STAGES     = fbra_pkg::DEF_STAGES,
    parameter int COUNT_BITS = fbra_pkg::DEF_COUNT_BITS,
    localparam int PB = $clog2(PRODUCERS)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [2:0]            kind,
    input  logic [PB-1:0]         producer,
    input  logic [2:0]            stage,
    input  logic [1:0]            priority_req,
    input  logic [15:0]           units,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  ok,
    output logic [COUNT_BITS-1:0] cell_demand,
    output logic [COUNT_BITS-1:0] cell_granted,
    output logic [COUNT_BITS-1:0] cell_used,
    output logic [COUNT_BITS-1:0] cell_remaining,
    output logic [COUNT_BITS-1:0] cell_suggested,
    input  logic                  cfg_we,
    input  logic [2:0]            cfg_index,
    input  logic [31:0]           cfg_data
);

    localparam int N    = PRODUCERS * STAGES * fbra_pkg::PRIORITIES;
    localparam int CB   = $clog2(N);
    localparam int NCUR = STAGES * fbra_pkg::PRIORITIES;
    localparam int CURB = $clog2(NCUR);
    localparam int W    = (COUNT_BITS > 16) ? COUNT_BITS : 16;
    localparam logic [W:0] CMAX = (W + 1)'({COUNT_BITS{1'b1}});

    localparam logic [3:0] S_CLR    = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_RD     = 4'd2;
    localparam logic [3:0] S_MOD    = 4'd3;
    localparam logic [3:0] S_BF_RD  = 4'd4;
    localparam logic [3:0] S_BF_WR  = 4'd5;
    localparam logic [3:0] S_SL_RD  = 4'd6;
    localparam logic [3:0] S_SL_CAP = 4'd7;
    localparam logic [3:0] S_SL_RES = 4'd8;
    localparam logic [3:0] S_SL_RR  = 4'd9;
    localparam logic [3:0] S_SL_WB  = 4'd10;
    localparam logic [3:0] S_RES_RD = 4'd11;
    localparam logic [3:0] S_RES    = 4'd12;

    // Saturating add of two counters.
    function automatic logic [COUNT_BITS-1:0] sat_add(logic [W:0] a, logic [W:0] b);
        logic [W:0] s;
        s = a + b;
        if (s > CMAX)
        begin
            return {COUNT_BITS{1'b1}};
        end
        return s[COUNT_BITS-1:0];
    endfunction

    // Flat cell index of a producer, stage and priority.
    function automatic logic [CB-1:0] cell_of(logic [PB-1:0] p, logic [2:0] s,
                                              logic [1:0] q);
        int c;
        c = (int'(p) * STAGES + int'(s)) * fbra_pkg::PRIORITIES + int'(q);
        return CB'(c);
    endfunction

    logic [3:0]            state_reg;
    logic [3:0]            state_next;
    logic [CB-1:0]         idx_reg;
    logic                  open_reg;
    logic                  sealed_reg;
    logic                  roll_reg;
    logic [2:0]            s_cnt_reg;
    logic [1:0]            q_cnt_reg;
    logic [PB-1:0]         p_cnt_reg;
    logic [PB-1:0]         cursors_reg [NCUR];
    logic [31:0]           limits_reg [fbra_pkg::NUM_LIMIT_REGS];
    logic                  out_valid_reg;
    logic                  ok_reg;

    logic [2:0]            kind_reg;
    logic [15:0]           units_reg;
    logic [CB-1:0]         cell_reg;
    logic                  addr_ok_reg;

    logic [COUNT_BITS-1:0] dem_out_reg;
    logic [COUNT_BITS-1:0] gr_out_reg;
    logic [COUNT_BITS-1:0] use_out_reg;
    logic [COUNT_BITS-1:0] rem_out_reg;
    logic [COUNT_BITS-1:0] sug_out_reg;
    logic                  ok_out_reg;

    logic [COUNT_BITS-1:0] dem_rd;
    logic [COUNT_BITS-1:0] gr_rd;
    logic [COUNT_BITS-1:0] use_rd;
    logic [COUNT_BITS-1:0] den_rd;
    logic [COUNT_BITS-1:0] def_rd;
    logic [COUNT_BITS-1:0] sug_rd;

    logic                  accept;
    logic                  in_addr_ok;
    logic                  wide_open;
    logic                  out_free;
    logic [CURB-1:0]       cur_idx;
    logic                  seal_cell_last;
    logic [CB-1:0]         seal_cell;
    logic [CB-1:0]         raddr;
    logic [CB-1:0]         waddr;
    logic [COUNT_BITS-1:0] wdata;
    logic [COUNT_BITS-1:0] wdata_sug;
    logic [COUNT_BITS-1:0] mod_val;
    logic [COUNT_BITS-1:0] sum_ud;
    logic [COUNT_BITS-1:0] sum_all;
    logic                  short_acq;
    logic [W:0]            units_w;
    logic [W:0]            g_w;
    logic [W:0]            u_w;
    logic                  we_dem;
    logic                  we_gr;
    logic                  we_use;
    logic                  we_den;
    logic                  we_def;
    logic                  we_sug;
    logic                  clr_wr;

    fbra_pkg::rr_cmd_t     rr_cmd;
    fbra_pkg::rr_stat_t    rr_stat;
    logic [PB-1:0]         rr_cur;
    logic [COUNT_BITS-1:0] rr_gr;

    assign accept     = in_valid && !in_stall;
    assign in_stall   = (state_reg != S_IDLE);
    assign in_addr_ok = (int'(producer) < PRODUCERS) && (int'(stage) < STAGES) &&
                        (int'(priority_req) < fbra_pkg::PRIORITIES);
    assign wide_open  = open_reg;
    assign out_free   = !out_valid_reg || !out_stall;
    assign cur_idx    = CURB'(int'(s_cnt_reg) * fbra_pkg::PRIORITIES + int'(q_cnt_reg));
    assign seal_cell  = cell_of(p_cnt_reg, s_cnt_reg, q_cnt_reg);
    assign seal_cell_last = (int'(p_cnt_reg) == PRODUCERS - 1);

    // Arithmetic on the addressed cell.
    assign units_w = (W + 1)'(units_reg);
    assign g_w     = (W + 1)'(gr_rd);
    assign u_w     = (W + 1)'(use_rd);
    assign short_acq = (u_w > g_w) || (units_w > (g_w - u_w));
    assign sum_ud  = sat_add((W + 1)'(use_rd), (W + 1)'(den_rd));
    assign sum_all = sat_add((W + 1)'(sum_ud), (W + 1)'(def_rd));

    always_comb
    begin
        case (kind_reg)
            fbra_pkg::KIND_DECLARE: mod_val = sat_add((W + 1)'(dem_rd), units_w);
            fbra_pkg::KIND_ACQUIRE: mod_val = short_acq ?
                                              sat_add((W + 1)'(den_rd), units_w) :
                                              COUNT_BITS'(u_w + units_w);
            fbra_pkg::KIND_DEFER:   mod_val = sat_add((W + 1)'(def_rd), units_w);
            default:                mod_val = '0;
        endcase
    end

    // Table port control.
    assign clr_wr = (state_reg == S_CLR) || (state_reg == S_BF_WR);
    assign we_dem = clr_wr || (state_reg == S_MOD && kind_reg == fbra_pkg::KIND_DECLARE);
    assign we_gr  = clr_wr || (state_reg == S_SL_WB);
    assign we_use = clr_wr ||
                    (state_reg == S_MOD && kind_reg == fbra_pkg::KIND_ACQUIRE && !short_acq);
    assign we_den = clr_wr ||
                    (state_reg == S_MOD && kind_reg == fbra_pkg::KIND_ACQUIRE && short_acq);
    assign we_def = clr_wr || (state_reg == S_MOD && kind_reg == fbra_pkg::KIND_DEFER);
    assign we_sug = (state_reg == S_CLR) || (state_reg == S_BF_WR && roll_reg);

    always_comb
    begin
        case (state_reg)
            S_BF_RD: raddr = idx_reg;
            S_SL_RD: raddr = seal_cell;
            default: raddr = cell_reg;
        endcase
        case (state_reg)
            S_MOD:   waddr = cell_reg;
            S_SL_WB: waddr = seal_cell;
            default: waddr = idx_reg;
        endcase
        case (state_reg)
            S_MOD:   wdata = mod_val;
            S_SL_WB: wdata = rr_gr;
            default: wdata = '0;
        endcase
        wdata_sug = (state_reg == S_BF_WR) ? sum_all : '0;
    end

    fbra_ram #(.WIDTH(COUNT_BITS), .DEPTH(N)) u_dem_ram (
        .clk(clk), .we(we_dem), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(dem_rd)
    );
    fbra_ram #(.WIDTH(COUNT_BITS), .DEPTH(N)) u_gr_ram (
        .clk(clk), .we(we_gr), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(gr_rd)
    );
    fbra_ram #(.WIDTH(COUNT_BITS), .DEPTH(N)) u_use_ram (
        .clk(clk), .we(we_use), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(use_rd)
    );
    fbra_ram #(.WIDTH(COUNT_BITS), .DEPTH(N)) u_den_ram (
        .clk(clk), .we(we_den), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(den_rd)
    );
    fbra_ram #(.WIDTH(COUNT_BITS), .DEPTH(N)) u_def_ram (
        .clk(clk), .we(we_def), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(def_rd)
    );
    fbra_ram #(.WIDTH(COUNT_BITS), .DEPTH(N)) u_sug_ram (
        .clk(clk), .we(we_sug), .waddr(waddr), .wdata(wdata_sug), .raddr(raddr),
        .rdata(sug_rd)
    );

    // Round-robin unit commands.
    always_comb
    begin
        rr_cmd            = '0;
        rr_cmd.cur_load   = (state_reg == S_SL_RD) && (p_cnt_reg == '0);
        rr_cmd.avail_load = rr_cmd.cur_load && (q_cnt_reg == '0);
        rr_cmd.ld         = (state_reg == S_SL_CAP);
        rr_cmd.reserve    = (state_reg == S_SL_RES);
        rr_cmd.step       = (state_reg == S_SL_RR);
    end

    fbra_rr #(.PRODUCERS(PRODUCERS), .COUNT_BITS(COUNT_BITS)) u_rr (
        .clk(clk),
        .rst_n(rst_n),
        .cmd(rr_cmd),
        .idx(p_cnt_reg),
        .ld_data(dem_rd),
        .budget(limits_reg[s_cnt_reg][15:0]),
        .reserve(limits_reg[s_cnt_reg][31:16]),
        .cur_in(cursors_reg[cur_idx]),
        .cur_out(rr_cur),
        .gr_out(rr_gr),
        .stat(rr_stat)
    );

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLR:
            begin
                if (int'(idx_reg) == N - 1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    case (kind)
                        fbra_pkg::KIND_BEGIN:
                            state_next = S_BF_RD;
                        fbra_pkg::KIND_DECLARE:
                            state_next = (wide_open && !sealed_reg && units != '0 &&
                                          in_addr_ok) ? S_RD : S_RES_RD;
                        fbra_pkg::KIND_SEAL:
                            state_next = (wide_open && !sealed_reg) ? S_SL_RD : S_RES_RD;
                        fbra_pkg::KIND_ACQUIRE, fbra_pkg::KIND_DEFER:
                            state_next = (wide_open && sealed_reg && units != '0 &&
                                          in_addr_ok) ? S_RD : S_RES_RD;
                        default:
                            state_next = S_RES_RD;
                    endcase
                end
            end
            S_RD:     state_next = S_MOD;
            S_MOD:    state_next = S_RES_RD;
            S_BF_RD:  state_next = S_BF_WR;
            S_BF_WR:  state_next = (int'(idx_reg) == N - 1) ? S_RES_RD : S_BF_RD;
            S_SL_RD:  state_next = S_SL_CAP;
            S_SL_CAP:
            begin
                if (seal_cell_last)
                begin
                    state_next = (q_cnt_reg == '0) ? S_SL_RES : S_SL_RR;
                end
                else
                begin
                    state_next = S_SL_RD;
                end
            end
            S_SL_RES: state_next = S_SL_RR;
            S_SL_RR:
            begin
                if (rr_stat.done)
                begin
                    state_next = S_SL_WB;
                end
            end
            S_SL_WB:
            begin
                if (seal_cell_last)
                begin
                    if (int'(q_cnt_reg) == fbra_pkg::PRIORITIES - 1 &&
                        int'(s_cnt_reg) == STAGES - 1)
                    begin
                        state_next = S_RES_RD;
                    end
                    else
                    begin
                        state_next = S_SL_RD;
                    end
                end
            end
            S_RES_RD: state_next = S_RES;
            S_RES:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            idx_reg       <= '0;
            open_reg      <= 1'b0;
            sealed_reg    <= 1'b0;
            roll_reg      <= 1'b0;
            s_cnt_reg     <= '0;
            q_cnt_reg     <= '0;
            p_cnt_reg     <= '0;
            out_valid_reg <= 1'b0;
            ok_reg        <= 1'b0;
            for (int i = 0; i < NCUR; i++)
            begin
                cursors_reg[i] <= '0;
            end
            for (int i = 0; i < fbra_pkg::NUM_LIMIT_REGS; i++)
            begin
                limits_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;

            // Configuration writes.
            if (cfg_we && int'(cfg_index) < fbra_pkg::NUM_LIMIT_REGS)
            begin
                limits_reg[cfg_index] <= cfg_data;
            end

            // Output word handshake.
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == S_RES && out_free)
            begin
                out_valid_reg <= 1'b1;
            end

            case (state_reg)
                S_CLR:
                begin
                    idx_reg <= (int'(idx_reg) == N - 1) ? '0 : idx_reg + 1'b1;
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        idx_reg   <= '0;
                        s_cnt_reg <= '0;
                        q_cnt_reg <= '0;
                        p_cnt_reg <= '0;
                        roll_reg  <= open_reg && sealed_reg;
                        case (kind)
                            fbra_pkg::KIND_BEGIN: ok_reg <= 1'b1;
                            fbra_pkg::KIND_SEAL:  ok_reg <= open_reg;
                            fbra_pkg::KIND_QUERY: ok_reg <= 1'b1;
                            default:              ok_reg <= 1'b0;
                        endcase
                    end
                end
                S_MOD:
                begin
                    ok_reg <= !(kind_reg == fbra_pkg::KIND_ACQUIRE && short_acq);
                end
                S_BF_WR:
                begin
                    if (int'(idx_reg) == N - 1)
                    begin
                        open_reg   <= 1'b1;
                        sealed_reg <= 1'b0;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_SL_CAP:
                begin
                    p_cnt_reg <= seal_cell_last ? '0 : p_cnt_reg + 1'b1;
                end
                S_SL_WB:
                begin
                    if (seal_cell_last)
                    begin
                        p_cnt_reg            <= '0;
                        cursors_reg[cur_idx] <= rr_cur;
                        if (int'(q_cnt_reg) == fbra_pkg::PRIORITIES - 1)
                        begin
                            q_cnt_reg <= '0;
                            if (int'(s_cnt_reg) == STAGES - 1)
                            begin
                                sealed_reg <= 1'b1;
                            end
                            else
                            begin
                                s_cnt_reg <= s_cnt_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            q_cnt_reg <= q_cnt_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        p_cnt_reg <= p_cnt_reg + 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Command fields and result word.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg    <= kind;
            units_reg   <= units;
            addr_ok_reg <= in_addr_ok;
            cell_reg    <= in_addr_ok ? cell_of(producer, stage, priority_req) : '0;
        end
        if (state_reg == S_RES && out_free)
        begin
            ok_out_reg <= ok_reg;
            if (addr_ok_reg)
            begin
                dem_out_reg <= dem_rd;
                gr_out_reg  <= gr_rd;
                use_out_reg <= use_rd;
                rem_out_reg <= (gr_rd >= use_rd) ? gr_rd - use_rd : '0;
                sug_out_reg <= sug_rd;
            end
            else
            begin
                dem_out_reg <= '0;
                gr_out_reg  <= '0;
                use_out_reg <= '0;
                rem_out_reg <= '0;
                sug_out_reg <= '0;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign ok             = ok_out_reg;
    assign cell_demand    = dem_out_reg;
    assign cell_granted   = gr_out_reg;
    assign cell_used      = use_out_reg;
    assign cell_remaining = rem_out_reg;
    assign cell_suggested = sug_out_reg;

endmodule

FILE: rtl/fbra_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// fbra_checker
// Port-level checks of the frame budget round-robin allocator.
// ============================================================================
module fbra_checker #(
    parameter int PRODUCERS  = fbra_pkg::DEF_PRODUCERS,
    parameter int COUNT_BITS = fbra_pkg::DEF_COUNT_BITS,
    localparam int PB = $clog2(PRODUCERS)
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_stall,
    input logic [2:0]            kind,
    input logic [PB-1:0]         producer,
    input logic [2:0]            stage,
    input logic [1:0]            priority_req,
    input logic [15:0]           units,
    input logic                  out_valid,
    input logic                  out_stall,
    input logic                  ok,
    input logic [COUNT_BITS-1:0] cell_demand,
    input logic [COUNT_BITS-1:0] cell_granted,
    input logic [COUNT_BITS-1:0] cell_used,
    input logic [COUNT_BITS-1:0] cell_remaining,
    input logic [COUNT_BITS-1:0] cell_suggested,
    input logic                  cfg_we,
    input logic [2:0]            cfg_index,
    input logic [31:0]           cfg_data
);

    // A stalled result word stays and holds its demand and ok flag.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(cell_demand) && $stable(ok))
        else $error("result word changed while stalled");

    // The block takes one command at a time.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("command accepted while another is in work");

    // Use never runs past the grant, and the grant never past demand.
    a_grant_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (cell_used <= cell_granted) && (cell_granted <= cell_demand))
        else $error("cell counters out of order");

    // Remaining units match grant minus use.
    a_remaining: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (cell_remaining == cell_granted - cell_used))
        else $error("remaining units inconsistent");

endmodule

bind frame_budget_round_robin_allocator fbra_checker #(
    .PRODUCERS(PRODUCERS),
    .COUNT_BITS(COUNT_BITS)
) u_fbra_checker (.*);
